[rtl/dltq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types, codes and helpers of the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W     = $clog2(NUM_SLOTS);
  localparam int unsigned PTR_W     = IDX_W + 1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

  localparam logic [1:0] CMD_PRIME  = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;

  localparam logic [1:0] KIND_PRIME  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_CHECK  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  timer_id;
    logic [31:0] ref_value;
    logic [31:0] delay;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] slot_ref;
    logic        flag;
    logic [31:0] next_timeout;
    logic        has_next;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_STEP, OP_UNLINK, OP_CU_INIT, OP_CU_STEP,
    OP_INS_INIT, OP_INS_STEP, OP_INS_DONE, OP_PRIME_NOP, OP_CAN_HIT,
    OP_CAN_MISS, OP_FIRE, OP_CHECK_DONE
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_UNL, ST_CU_INIT, ST_CU, ST_INS_INIT, ST_INS,
    ST_CAN, ST_FIRE
  } ctl_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic       delay_zero;
    logic       id_armed;
    logic       head_null;
    logic       cur_null;
    logic       cur_is_id;
    logic       ref_hit;
    logic       cu_last;
    logic       ins_stop;
    logic       fire_ok;
  } dp_stat_t;

  function automatic logic [31:0] clamp_gap(logic [31:0] v, logic [15:0] gap);
    return (v < {16'd0, gap}) ? {16'd0, gap} : v;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[rtl/dltq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer: walks the slot list one entry per cycle and issues datapath ops.
// ----------------------------------------------------------------------------
module dltq_ctrl import dltq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_o    = OP_LOAD;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.cmd == CMD_PRIME) begin
          if (stat_i.delay_zero) begin
            op_o    = OP_PRIME_NOP;
            state_d = ST_IDLE;
          end else if (stat_i.id_armed) begin
            state_d = ST_UNL;
          end else begin
            state_d = ST_CU_INIT;
          end
        end else if (stat_i.cmd == CMD_CANCEL) begin
          state_d = ST_CAN;
        end else if (stat_i.head_null) begin
          op_o    = OP_CHECK_DONE;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CU_INIT;
        end
      end
      ST_UNL: begin
        if (stat_i.cur_null) begin
          state_d = ST_CU_INIT;
        end else if (stat_i.cur_is_id) begin
          op_o    = OP_UNLINK;
          state_d = ST_CU_INIT;
        end else begin
          op_o = OP_STEP;
        end
      end
      ST_CU_INIT: begin
        op_o    = OP_CU_INIT;
        state_d = ST_CU;
      end
      ST_CU: begin
        op_o = OP_CU_STEP;
        if (stat_i.cu_last) begin
          state_d = (stat_i.cmd == CMD_PRIME) ? ST_INS_INIT : ST_FIRE;
        end
      end
      ST_INS_INIT: begin
        op_o    = OP_INS_INIT;
        state_d = ST_INS;
      end
      ST_INS: begin
        if (stat_i.ins_stop) begin
          op_o    = OP_INS_DONE;
          state_d = ST_IDLE;
        end else begin
          op_o = OP_INS_STEP;
        end
      end
      ST_CAN: begin
        if (stat_i.cur_null) begin
          op_o    = OP_CAN_MISS;
          state_d = ST_IDLE;
        end else if (stat_i.ref_hit) begin
          op_o    = OP_CAN_HIT;
          state_d = ST_IDLE;
        end else begin
          op_o = OP_STEP;
        end
      end
      ST_FIRE: begin
        if (stat_i.fire_ok) begin
          op_o = OP_FIRE;
        end else begin
          op_o    = OP_CHECK_DONE;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/dltq_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_dpath
// Slot store, list pointers, catch-up and insert arithmetic, result register.
// ----------------------------------------------------------------------------
module dltq_dpath import dltq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  req_t        req_i,
  input  dp_op_e      op_i,
  output dp_stat_t    stat_o,
  output res_t        res_o,
  output logic        res_valid_o
);

  logic [31:0]      delta_q [NUM_SLOTS];
  logic [PTR_W-1:0] next_q  [NUM_SLOTS];
  logic [31:0]      refv_q  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] armed_q;

  req_t             req_q;
  logic [PTR_W-1:0] cur_q, prev_q, head_q;
  logic [31:0]      off_q, d_q, lut_q;
  logic [15:0]      gap_q;
  res_t             res_q;
  logic             res_valid_q;

  logic [IDX_W-1:0] cur_idx, nx_idx, head_idx, prev_idx, id_idx;
  logic [31:0]      dcur, dnx, dhead, off_rem;
  logic [PTR_W-1:0] ncur;
  logic             cur_null, prev_null, head_null;

  assign cur_idx   = cur_q[IDX_W-1:0];
  assign prev_idx  = prev_q[IDX_W-1:0];
  assign head_idx  = head_q[IDX_W-1:0];
  assign id_idx    = req_q.timer_id[IDX_W-1:0];
  assign dcur      = delta_q[cur_idx];
  assign ncur      = next_q[cur_idx];
  assign nx_idx    = ncur[IDX_W-1:0];
  assign dnx       = delta_q[nx_idx];
  assign dhead     = delta_q[head_idx];
  assign cur_null  = (cur_q == NULL_PTR);
  assign prev_null = (prev_q == NULL_PTR);
  assign head_null = (head_q == NULL_PTR);
  assign off_rem   = off_q - dcur;

  always_comb begin
    stat_o.cmd        = req_q.command;
    stat_o.delay_zero = (req_q.delay == 32'd0);
    stat_o.id_armed   = armed_q[id_idx];
    stat_o.head_null  = head_null;
    stat_o.cur_null   = cur_null;
    stat_o.cur_is_id  = (cur_q == {1'b0, req_q.timer_id});
    stat_o.ref_hit    = (refv_q[cur_idx] == req_q.ref_value);
    stat_o.cu_last    = cur_null || (dcur >= off_q) || (off_rem <= {16'd0, gap_q});
    stat_o.ins_stop   = cur_null || (d_q < dcur);
    stat_o.fire_ok    = !head_null && (dhead <= {16'd0, gap_q});
  end

  // slot store
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_UNLINK, OP_CAN_HIT: begin
        if (ncur != NULL_PTR) delta_q[nx_idx] <= sat_add(dnx, dcur);
        if (!prev_null) next_q[prev_idx] <= ncur;
        next_q[cur_idx] <= NULL_PTR;
      end
      OP_CU_STEP: begin
        if (!cur_null) begin
          delta_q[cur_idx] <= (dcur >= off_q) ? clamp_gap(dcur - off_q, gap_q)
                                              : {16'd0, gap_q};
        end
      end
      OP_INS_DONE: begin
        delta_q[id_idx] <= d_q;
        next_q[id_idx]  <= cur_q;
        refv_q[id_idx]  <= req_q.ref_value;
        if (!prev_null) next_q[prev_idx] <= {1'b0, req_q.timer_id};
        if (!cur_null) delta_q[cur_idx] <= clamp_gap(dcur - d_q, gap_q);
      end
      OP_FIRE: begin
        next_q[head_idx] <= NULL_PTR;
      end
      default: ;
    endcase
  end

  // working registers and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      head_q      <= NULL_PTR;
      lut_q       <= 32'd0;
      gap_q       <= 16'd4;
      cur_q       <= NULL_PTR;
      prev_q      <= NULL_PTR;
      off_q       <= 32'd0;
      d_q         <= 32'd0;
      req_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) gap_q <= cfg_wdata_i;
      res_valid_q <= 1'b0;
      case (op_i)
        OP_LOAD: begin
          req_q  <= req_i;
          cur_q  <= head_q;
          prev_q <= NULL_PTR;
        end
        OP_STEP: begin
          prev_q <= cur_q;
          cur_q  <= ncur;
        end
        OP_UNLINK, OP_CAN_HIT: begin
          if (prev_null) head_q <= ncur;
          armed_q[cur_idx] <= 1'b0;
          if (op_i == OP_CAN_HIT) begin
            res_q       <= '{KIND_CANCEL, cur_q[3:0], req_q.ref_value, 1'b1, 32'd0,
                             1'b0, 1'b1};
            res_valid_q <= 1'b1;
          end
        end
        OP_CU_INIT: begin
          off_q <= req_q.now_time - lut_q;
          cur_q <= head_q;
        end
        OP_CU_STEP: begin
          if (!cur_null && dcur < off_q) begin
            off_q <= off_rem;
            cur_q <= ncur;
          end
          if (stat_o.cu_last) lut_q <= req_q.now_time;
        end
        OP_INS_INIT: begin
          cur_q  <= head_q;
          prev_q <= NULL_PTR;
          d_q    <= req_q.delay;
        end
        OP_INS_STEP: begin
          d_q    <= clamp_gap(d_q - dcur, gap_q);
          prev_q <= cur_q;
          cur_q  <= ncur;
        end
        OP_INS_DONE: begin
          if (prev_null) head_q <= {1'b0, req_q.timer_id};
          armed_q[id_idx] <= 1'b1;
          res_q       <= '{KIND_PRIME, req_q.timer_id, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1};
          res_valid_q <= 1'b1;
        end
        OP_PRIME_NOP: begin
          res_q       <= '{KIND_PRIME, req_q.timer_id, 32'd0, armed_q[id_idx], 32'd0,
                           1'b0, 1'b1};
          res_valid_q <= 1'b1;
        end
        OP_CAN_MISS: begin
          res_q       <= '{KIND_CANCEL, 4'd0, req_q.ref_value, 1'b0, 32'd0, 1'b0, 1'b1};
          res_valid_q <= 1'b1;
        end
        OP_FIRE: begin
          head_q            <= next_q[head_idx];
          armed_q[head_idx] <= 1'b0;
          res_q       <= '{KIND_FIRED, head_q[3:0], refv_q[head_idx], 1'b0, 32'd0,
                           1'b0, 1'b0};
          res_valid_q <= 1'b1;
        end
        OP_CHECK_DONE: begin
          res_q       <= '{KIND_CHECK, 4'd0, 32'd0, 1'b0,
                           head_null ? 32'd0 : dhead, !head_null, 1'b1};
          res_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

[rtl/delta_list_timer_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Timer slots kept as a sorted delta list with prime, cancel and check.
// ----------------------------------------------------------------------------
// channel   signals                     handshake
// request   start, req_i                taken when start high and busy low
// result    res_valid_o, res_o          one cycle per result, cannot be held
// config    cfg_we_i, cfg_wdata_i       min_gap written when cfg_we_i high
//
// One list entry is visited per cycle by the sequencer walking the slot list.
// Prime: unlink walk (when the id is armed), catch-up, then insert; zero delay
// skips all three. Cancel: search by ref. Check: catch-up, one result per fired timer.
// Reset leaves the list empty, min_gap 4; results leave without stall.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core import dltq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output res_t        res_o,
  output logic        res_valid_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  dp_stat_t stat;
  dp_op_e   op;

  dltq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .op_o    (op)
  );

  dltq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .op_i        (op),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy) else $error("final result while busy");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy) else $error("idle before final result");

  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_FIRED |-> !res_o.last)
    else $error("fired result marked last");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

endmodule

[bench/delta_list_timer_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core_tb
// Self-checking bench for the delta list timer queue. Prime, cancel and
// check requests go in, mostly under random gaps. A predictor keeps its own sorted
// delta list and queues the results each request should give. A monitor
// compares every result strobe field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core_tb;
  import dltq_pkg::*;

  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  res_t        res_o;
  logic        res_valid_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  delta_list_timer_queue_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .res_o(res_o), .res_valid_o(res_valid_o), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  logic [31:0] gap_q;
  logic [31:0] delta_q [NUM_SLOTS];
  logic [4:0]  next_q  [NUM_SLOTS];
  logic        armed_q [NUM_SLOTS];
  logic [31:0] refv_q  [NUM_SLOTS];
  logic [4:0]  head_q;
  logic [31:0] stamp_q;
  logic [31:0] now_q;
  logic [31:0] used_refs [$];

  res_t timer_results [$];
  int   err_cnt;
  bit   idle_gaps;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] gap_clamp(logic [31:0] v);
    return (v < gap_q) ? gap_q : v;
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic list_unlink(input logic [4:0] s, input bit fold);
    logic [4:0] cur, prev, nx;
    cur = head_q;
    prev = NULL_PTR;
    for (int g = 0; g < NUM_SLOTS && cur < NUM_SLOTS; g++) begin
      if (cur == s) begin
        nx = next_q[cur];
        if (fold && nx < NUM_SLOTS) delta_q[nx] = add_sat(delta_q[nx], delta_q[cur]);
        if (prev < NUM_SLOTS) next_q[prev] = nx;
        else head_q = nx;
        next_q[cur] = NULL_PTR;
        armed_q[cur] = 1'b0;
        return;
      end
      prev = cur;
      cur = next_q[cur];
    end
  endtask

  task automatic list_catch_up(input logic [31:0] now);
    logic [31:0] off;
    logic [4:0]  cur;
    off = now - stamp_q;
    cur = head_q;
    for (int g = 0; g < NUM_SLOTS && cur < NUM_SLOTS; g++) begin
      if (delta_q[cur] >= off) begin
        delta_q[cur] = gap_clamp(delta_q[cur] - off);
        break;
      end
      off -= delta_q[cur];
      delta_q[cur] = gap_q;
      if (off <= gap_q) break;
      cur = next_q[cur];
    end
    stamp_q = now;
  endtask

  task automatic list_insert(input logic [4:0] s);
    logic [4:0]  cur, prev;
    logic [31:0] d;
    int g;
    cur = head_q;
    prev = NULL_PTR;
    d = delta_q[s];
    for (g = 0; g < NUM_SLOTS && cur < NUM_SLOTS; g++) begin
      if (d < delta_q[cur]) break;
      d = gap_clamp(d - delta_q[cur]);
      prev = cur;
      cur = next_q[cur];
    end
    if (g >= NUM_SLOTS) cur = NULL_PTR;
    delta_q[s] = d;
    next_q[s] = cur;
    if (prev < NUM_SLOTS) next_q[prev] = s;
    else head_q = s;
    if (cur < NUM_SLOTS) delta_q[cur] = gap_clamp(delta_q[cur] - d);
    armed_q[s] = 1'b1;
  endtask

  function automatic res_t mk_res(logic [1:0] k, logic [3:0] sl, logic [31:0] r,
                                  logic f, logic [31:0] nt, logic hn, logic l);
    res_t x;
    x.kind = k; x.slot = sl; x.slot_ref = r; x.flag = f;
    x.next_timeout = nt; x.has_next = hn; x.last = l;
    return x;
  endfunction

  task automatic predict_timer(input req_t q);
    logic [4:0] cur, h;
    int n;
    n = 0;
    if (q.command == CMD_PRIME) begin
      if (q.delay != 0) begin
        if (armed_q[q.timer_id]) list_unlink({1'b0, q.timer_id}, 1'b1);
        delta_q[q.timer_id] = q.delay;
        refv_q[q.timer_id] = q.ref_value;
        list_catch_up(q.now_time);
        list_insert({1'b0, q.timer_id});
      end
      timer_results.push_back(mk_res(KIND_PRIME, q.timer_id, '0,
                                     armed_q[q.timer_id], '0, 1'b0, 1'b1));
    end else if (q.command == CMD_CANCEL) begin
      cur = head_q;
      for (int g = 0; g < NUM_SLOTS && cur < NUM_SLOTS; g++) begin
        if (refv_q[cur] == q.ref_value) begin
          list_unlink(cur, 1'b1);
          timer_results.push_back(mk_res(KIND_CANCEL, cur[3:0], q.ref_value, 1'b1,
                                         '0, 1'b0, 1'b1));
          return;
        end
        cur = next_q[cur];
      end
      timer_results.push_back(mk_res(KIND_CANCEL, '0, q.ref_value, 1'b0, '0, 1'b0,
                                     1'b1));
    end else begin
      if (head_q < NUM_SLOTS) begin
        list_catch_up(q.now_time);
        while (n < NUM_SLOTS && head_q < NUM_SLOTS && delta_q[head_q] <= gap_q) begin
          h = head_q;
          list_unlink(h, 1'b0);
          timer_results.push_back(mk_res(KIND_FIRED, h[3:0], refv_q[h], 1'b0, '0,
                                         1'b0, 1'b0));
          n++;
        end
      end
      if (head_q < NUM_SLOTS)
        timer_results.push_back(mk_res(KIND_CHECK, '0, '0, 1'b0, delta_q[head_q],
                                       1'b1, 1'b1));
      else
        timer_results.push_back(mk_res(KIND_CHECK, '0, '0, 1'b0, '0, 1'b0, 1'b1));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && res_valid_o) begin
      if (timer_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(res_o.kind), '0);
      end else begin
        w = timer_results.pop_front();
        if (res_o.kind !== w.kind)
          report_mismatch("kind", 32'(res_o.kind), 32'(w.kind));
        if (res_o.slot !== w.slot)
          report_mismatch("slot", 32'(res_o.slot), 32'(w.slot));
        if (res_o.slot_ref !== w.slot_ref)
          report_mismatch("slot_ref", res_o.slot_ref, w.slot_ref);
        if (res_o.flag !== w.flag)
          report_mismatch("flag", 32'(res_o.flag), 32'(w.flag));
        if (res_o.next_timeout !== w.next_timeout)
          report_mismatch("next_timeout", res_o.next_timeout, w.next_timeout);
        if (res_o.has_next !== w.has_next)
          report_mismatch("has_next", 32'(res_o.has_next), 32'(w.has_next));
        if (res_o.last !== w.last)
          report_mismatch("last", 32'(res_o.last), 32'(w.last));
      end
    end
  end

  task automatic send_request(input req_t q);
    int pause;
    if (idle_gaps && $urandom_range(0, 2) == 0) begin
      pause = $urandom_range(1, 10);
      repeat (pause) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_timer(q);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (timer_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_gap(input logic [15:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gap_q = {16'd0, v};
  endtask

  task automatic do_prime(input logic [3:0] id, input logic [31:0] r,
                          input logic [31:0] d, input logic [31:0] dt);
    req_t q;
    now_q += dt;
    q = '{command: CMD_PRIME, timer_id: id, ref_value: r, delay: d, now_time: now_q};
    used_refs.push_back(r);
    send_request(q);
  endtask

  task automatic do_cancel(input logic [31:0] r);
    req_t q;
    q = '{command: CMD_CANCEL, timer_id: 4'($urandom), ref_value: r,
          delay: $urandom, now_time: $urandom};
    send_request(q);
  endtask

  task automatic do_check(input logic [1:0] c, input logic [31:0] dt);
    req_t q;
    now_q += dt;
    q = '{command: c, timer_id: 4'($urandom), ref_value: $urandom, delay: $urandom,
          now_time: now_q};
    send_request(q);
  endtask

  task automatic test_directed();
    do_check(CMD_CHECK, 32'd10);
    do_prime(4'd0, 32'hFFFF_FFFF, 32'd100, 32'd0);
    do_prime(4'd15, 32'h0000_0001, 32'hFFFF_FFFF, 32'd1);
    do_prime(4'd7, 32'h5555_AAAA, 32'd50, 32'd0);
    do_prime(4'd3, 32'h1234_5678, 32'd0, 32'd0);
    do_prime(4'd7, 32'hAAAA_5555, 32'd200, 32'd3);
    do_prime(4'd8, 32'h0F0F_0F0F, 32'd1, 32'd0);
    do_cancel(32'hDEAD_BEEF);
    do_cancel(32'hFFFF_FFFF);
    do_check(CMD_UNDEF, 32'd5);
    do_check(CMD_CHECK, 32'd300);
    do_cancel(32'h0000_0001);
    do_prime(4'd2, 32'h2222_2222, 32'hFFFF_FFF0, 32'd0);
    do_prime(4'd4, 32'h4444_4444, 32'hFFFF_FFF8, 32'd0);
    do_cancel(32'h2222_2222);
    do_check(CMD_CHECK, 32'hFFFF_FFFF);
    do_check(CMD_CHECK, 32'd0);
    do_cancel(32'h4444_4444);
  endtask

  task automatic test_random(input int count);
    logic [31:0] r, d;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
        r = (used_refs.size() != 0 && $urandom_range(0, 3) == 0) ?
            used_refs[$urandom_range(0, used_refs.size() - 1)] : $urandom;
        do_prime(4'($urandom), r, d, $urandom_range(0, 60));
      end else if (sel < 65) begin
        r = (used_refs.size() != 0 && $urandom_range(0, 3) != 0) ?
            used_refs[$urandom_range(0, used_refs.size() - 1)] : $urandom;
        do_cancel(r);
      end else begin
        do_check(($urandom_range(0, 9) == 0) ? CMD_UNDEF : CMD_CHECK,
                 ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 150));
      end
    end
  endtask

  task automatic test_gap_settings();
    write_gap(16'd0);
    test_random(40);
    write_gap(16'hFFFF);
    do_prime(4'd5, 32'h0BAD_F00D, 32'h0001_0000, 32'd1);
    do_prime(4'd6, 32'h600D_CAFE, 32'd10, 32'd1);
    do_check(CMD_CHECK, 32'd2);
    test_random(20);
    write_gap(16'd25);
    test_random(40);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    err_cnt = 0;
    idle_gaps = 1'b1;
    gap_q = 32'd4;
    head_q = NULL_PTR;
    stamp_q = '0;
    now_q = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      delta_q[i] = '0;
      next_q[i] = NULL_PTR;
      armed_q[i] = 1'b0;
      refv_q[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(40);
    test_gap_settings();
    write_gap(16'd4);
    idle_gaps = 1'b0;
    test_random(30);
    wait_drained();
    if (err_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
